@@ src/cd_pkg.sv @@
// Shared constants and operation codes for the correlation distance block.
package cd_pkg;

	localparam int MAX_LENGTH_DEF    = 4096;
	localparam int VALUE_WIDTH_DEF   = 24;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int APB_ADDR_W = 3;

	// word index of each register (paddr[2])
	localparam logic [0:0] REG_CENTERED_MODE = 1'b0;

	typedef enum logic [2:0] {
		OP_NSXY,
		OP_SASB,
		OP_NSXX,
		OP_SASA,
		OP_NSYY,
		OP_SBSB,
		OP_XY,
		OP_PP
	} op_t;

endpackage

@@ src/correlation_distance.sv @@
// Pearson correlation distance (or cosine distance) of two streamed vectors.
//
// Element pairs arrive one per item on the slave stream; the item with tlast set closes
// the vectors and produces one result on the master stream: 1 - r in unsigned fixed point
// with FRACTION_BITS fraction bits, or invalid (distance 0) when an element was missing,
// the vector was empty or longer than MAX_LENGTH. One shared multiplier of VALUE_WIDTH
// by VALUE_WIDTH bits does all products. A pair runs 3 products through the multiplier,
// a missing pair none. At the end of a vector the exact multi-word products run limb by
// limb through the same multiplier (NL limbs, 4 at the defaults): 8 products in centered
// mode, 2 in cosine mode, followed, when P*P < X*Y, by a square-root/divide recurrence.
// The block takes no item during that time, but a result waiting in the output register
// does not stop the next item from being taken.
// centered_mode lies at byte address 0 of the APB port and resets to 1.
module correlation_distance import cd_pkg::*; #(
	parameter int MAX_LENGTH    = MAX_LENGTH_DEF,
	parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        s_tvalid,
	output logic                                        s_tready,
	// value_a, value_b
	input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]          s_tdata,
	// missing
	input  logic                                        s_tuser,
	input  logic                                        s_tlast,
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	// distance
	output logic [((FRACTION_BITS+2+7)/8)*8-1:0]        m_tdata,
	// invalid
	output logic                                        m_tuser,
	input  logic                                        psel,
	input  logic                                        penable,
	input  logic                                        pwrite,
	input  logic [APB_ADDR_W-1:0]                       paddr,
	input  logic [31:0]                                 pwdata,
	output logic [31:0]                                 prdata,
	output logic                                        pready
);

	localparam int VW   = VALUE_WIDTH;
	localparam int LW   = VALUE_WIDTH;
	localparam int CW   = $clog2(MAX_LENGTH + 1);
	localparam int SUMW = VW + CW;
	localparam int SQW  = 2*VW + CW - 1;
	localparam int EW   = 2*CW + 2*VW - 1;
	localparam int SRW  = EW + 1;
	localparam int NL   = (EW + LW - 1) / LW;
	localparam int LB   = $clog2(NL);
	localparam int OPW  = NL * LW;
	localparam int AW   = 2*OPW + 1;
	localparam int MSW  = $clog2(2*NL - 1);
	localparam int XYW  = 2*EW;
	localparam int RW   = XYW + FRACTION_BITS + 4;
	localparam int DW   = FRACTION_BITS + 2;
	localparam int MW   = FRACTION_BITS + 2;
	localparam int RCW  = $clog2(FRACTION_BITS + 1);
	localparam int OW   = ((DW + 7) / 8) * 8;
	localparam logic [DW-1:0] ONE = {{(DW-1){1'b0}}, 1'b1} << FRACTION_BITS;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PAB,
		S_PAA,
		S_PBB,
		S_PEND,
		S_FINISH,
		S_CHKD,
		S_LOAD,
		S_MAC,
		S_DRAIN,
		S_STORE,
		S_CMP,
		S_TRIAL,
		S_ROOT,
		S_RESULT,
		S_EMIT
	} state_t;

	state_t state_q;

	logic                   centered_q;
	logic signed [SUMW-1:0] sum_first_q;
	logic signed [SUMW-1:0] sum_second_q;
	logic signed [SQW-1:0]  sum_cross_q;
	logic signed [SQW-1:0]  sum_sq_first_q;
	logic signed [SQW-1:0]  sum_sq_second_q;
	logic [CW-1:0]          element_count_q;
	logic                   saw_missing_q;

	logic [VW-1:0]          a_q;
	logic [VW-1:0]          b_q;
	logic                   last_q;

	op_t                    op_q;
	logic [NL-1:0][LW-1:0]  op_u_q;
	logic [NL-1:0][LW-1:0]  op_v_q;
	logic                   neg_q;
	logic [LB-1:0]          i_q;
	logic [LB-1:0]          j_q;
	logic signed [AW-1:0]   acc_q;
	logic signed [SRW-1:0]  p_q;
	logic signed [SRW-1:0]  x_q;
	logic signed [SRW-1:0]  y_q;
	logic [XYW-1:0]         xy_q;
	logic [RW-1:0]          rem_q;
	logic [RW-1:0]          dd_q;
	logic [RW-1:0]          trial_q;
	logic [MW-1:0]          m_q;
	logic [RCW-1:0]         rc_q;

	logic [DW-1:0]          res_dist_q;
	logic                   res_inv_q;
	logic                   m_tvalid_q;
	logic [DW-1:0]          m_dist_q;
	logic                   m_inv_q;

	logic [LW-1:0]          mul_x;
	logic [LW-1:0]          mul_y;
	logic [2*LW-1:0]        mul_s1;
	logic [MSW-1:0]         msh_s1;
	logic                   pneg_s1;
	logic                   mv_s1;

	logic [VW-1:0]          a_mag;
	logic [VW-1:0]          b_mag;
	logic signed [VW-1:0]   a_in;
	logic signed [VW-1:0]   b_in;
	logic                   in_acc;
	logic                   cfg_wr;

	logic signed [SRW-1:0]  n_ext;
	logic signed [SRW-1:0]  sa_ext;
	logic signed [SRW-1:0]  sb_ext;
	logic signed [SRW-1:0]  sxy_ext;
	logic signed [SRW-1:0]  sxx_ext;
	logic signed [SRW-1:0]  syy_ext;
	logic signed [SRW-1:0]  src_u;
	logic signed [SRW-1:0]  src_v;
	logic                   src_sub;
	logic                   src_clr;

	logic [AW-1:0]          term;
	logic [AW-1:0]          acc_next;
	logic [SQW-1:0]         prod_ext;
	logic [RW-1:0]          rem4;
	logic [MW:0]            qsum;
	logic [FRACTION_BITS:0] q_val;
	logic [DW-1:0]          dist_val;

	function automatic logic [OPW-1:0] mag(input logic [SRW-1:0] v);
		logic [SRW-1:0] t;
		t = v[SRW-1] ? (~v + 1'b1) : v;
		return OPW'(t);
	endfunction

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign a_in     = s_tdata[VW-1:0];
	assign b_in     = s_tdata[2*VW-1:VW];

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OW'(m_dist_q);
	assign m_tuser  = m_inv_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CENTERED_MODE);
	assign prdata = (paddr[2] == REG_CENTERED_MODE) ? {31'b0, centered_q} : 32'b0;

	assign a_mag = a_q[VW-1] ? (~a_q + 1'b1) : a_q;
	assign b_mag = b_q[VW-1] ? (~b_q + 1'b1) : b_q;

	assign n_ext   = SRW'(element_count_q);
	assign sa_ext  = SRW'(sum_first_q);
	assign sb_ext  = SRW'(sum_second_q);
	assign sxy_ext = SRW'(sum_cross_q);
	assign sxx_ext = SRW'(sum_sq_first_q);
	assign syy_ext = SRW'(sum_sq_second_q);

	always_comb begin
		src_u   = n_ext;
		src_v   = sxy_ext;
		src_sub = 1'b0;
		src_clr = 1'b1;
		case (op_q)
			OP_NSXY: begin
				src_u = n_ext;
				src_v = sxy_ext;
			end
			OP_SASB: begin
				src_u   = sa_ext;
				src_v   = sb_ext;
				src_sub = 1'b1;
				src_clr = 1'b0;
			end
			OP_NSXX: begin
				src_u = n_ext;
				src_v = sxx_ext;
			end
			OP_SASA: begin
				src_u   = sa_ext;
				src_v   = sa_ext;
				src_sub = 1'b1;
				src_clr = 1'b0;
			end
			OP_NSYY: begin
				src_u = n_ext;
				src_v = syy_ext;
			end
			OP_SBSB: begin
				src_u   = sb_ext;
				src_v   = sb_ext;
				src_sub = 1'b1;
				src_clr = 1'b0;
			end
			OP_XY: begin
				src_u = x_q;
				src_v = y_q;
			end
			OP_PP: begin
				src_u = p_q;
				src_v = p_q;
			end
			default: begin
				src_u = n_ext;
				src_v = sxy_ext;
			end
		endcase
	end

	always_comb begin
		case (state_q)
			S_PAB: begin
				mul_x = a_mag;
				mul_y = b_mag;
			end
			S_PAA: begin
				mul_x = a_mag;
				mul_y = a_mag;
			end
			S_PBB: begin
				mul_x = b_mag;
				mul_y = b_mag;
			end
			default: begin
				mul_x = op_u_q[i_q];
				mul_y = op_v_q[j_q];
			end
		endcase
	end

	always_comb begin
		term = '0;
		for (int k = 0; k < 2*NL - 1; k++) begin
			if (msh_s1 == MSW'(k)) term = AW'(mul_s1) << (k * LW);
		end
	end

	assign acc_next = neg_q ? (acc_q - term) : (acc_q + term);
	assign prod_ext = SQW'(mul_s1);
	assign rem4     = rem_q << 2;
	assign qsum     = {1'b0, m_q} + 1'b1;
	assign q_val    = qsum[MW-1:1];
	assign dist_val = p_q[SRW-1] ? (ONE + DW'(q_val)) : (ONE - DW'(q_val));

	always_ff @(posedge clk) begin
		mul_s1  <= mul_x * mul_y;
		msh_s1  <= MSW'(i_q) + MSW'(j_q);
		pneg_s1 <= (state_q == S_PAB) && (a_q[VW-1] ^ b_q[VW-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			centered_q      <= 1'b1;
			sum_first_q     <= '0;
			sum_second_q    <= '0;
			sum_cross_q     <= '0;
			sum_sq_first_q  <= '0;
			sum_sq_second_q <= '0;
			element_count_q <= '0;
			saw_missing_q   <= 1'b0;
			m_tvalid_q      <= 1'b0;
			mv_s1           <= 1'b0;
			op_q            <= OP_NSXY;
			i_q             <= '0;
			j_q             <= '0;
			rc_q            <= '0;
		end else begin
			mv_s1 <= (state_q == S_MAC);
			if (cfg_wr) centered_q <= pwdata[0];
			if (m_tvalid_q && m_tready && (state_q != S_EMIT)) m_tvalid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						a_q    <= a_in;
						b_q    <= b_in;
						last_q <= s_tlast;
						if (element_count_q >= CW'(MAX_LENGTH)) begin
							saw_missing_q <= 1'b1;
							state_q       <= S_FINISH;
						end else begin
							element_count_q <= element_count_q + 1'b1;
							if (s_tuser) begin
								saw_missing_q <= 1'b1;
								state_q       <= S_FINISH;
							end else begin
								sum_first_q  <= sum_first_q + SUMW'(a_in);
								sum_second_q <= sum_second_q + SUMW'(b_in);
								state_q      <= S_PAB;
							end
						end
					end
				end
				S_PAB: state_q <= S_PAA;
				S_PAA: begin
					sum_cross_q <= pneg_s1 ? (sum_cross_q - prod_ext) : (sum_cross_q + prod_ext);
					state_q     <= S_PBB;
				end
				S_PBB: begin
					sum_sq_first_q <= sum_sq_first_q + prod_ext;
					state_q        <= S_PEND;
				end
				S_PEND: begin
					sum_sq_second_q <= sum_sq_second_q + prod_ext;
					state_q         <= S_FINISH;
				end
				S_FINISH: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (saw_missing_q || (element_count_q == '0)) begin
						res_dist_q <= '0;
						res_inv_q  <= 1'b1;
						state_q    <= S_EMIT;
					end else if (centered_q) begin
						op_q    <= OP_NSXY;
						state_q <= S_LOAD;
					end else begin
						p_q     <= sxy_ext;
						x_q     <= sxx_ext;
						y_q     <= syy_ext;
						state_q <= S_CHKD;
					end
				end
				S_CHKD: begin
					if (x_q[SRW-1] || (x_q == '0) || y_q[SRW-1] || (y_q == '0)) begin
						res_dist_q <= ONE;
						res_inv_q  <= 1'b0;
						state_q    <= S_EMIT;
					end else begin
						op_q    <= OP_XY;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					op_u_q  <= mag(src_u);
					op_v_q  <= mag(src_v);
					neg_q   <= src_u[SRW-1] ^ src_v[SRW-1] ^ src_sub;
					if (src_clr) acc_q <= '0;
					i_q     <= '0;
					j_q     <= '0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					if (mv_s1) acc_q <= acc_next;
					if (j_q == LB'(NL - 1)) begin
						j_q <= '0;
						if (i_q == LB'(NL - 1)) state_q <= S_DRAIN;
						else i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_DRAIN: begin
					acc_q   <= acc_next;
					i_q     <= '0;
					state_q <= S_STORE;
				end
				S_STORE: begin
					case (op_q)
						OP_NSXY: begin
							op_q    <= OP_SASB;
							state_q <= S_LOAD;
						end
						OP_SASB: begin
							p_q     <= acc_q[SRW-1:0];
							op_q    <= OP_NSXX;
							state_q <= S_LOAD;
						end
						OP_NSXX: begin
							op_q    <= OP_SASA;
							state_q <= S_LOAD;
						end
						OP_SASA: begin
							x_q     <= acc_q[SRW-1:0];
							op_q    <= OP_NSYY;
							state_q <= S_LOAD;
						end
						OP_NSYY: begin
							op_q    <= OP_SBSB;
							state_q <= S_LOAD;
						end
						OP_SBSB: begin
							y_q     <= acc_q[SRW-1:0];
							state_q <= S_CHKD;
						end
						OP_XY: begin
							xy_q    <= acc_q[XYW-1:0];
							op_q    <= OP_PP;
							state_q <= S_LOAD;
						end
						OP_PP: begin
							rem_q   <= RW'(acc_q[XYW-1:0]);
							state_q <= S_CMP;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_CMP: begin
					if (rem_q >= RW'(xy_q)) begin
						m_q     <= MW'(1) << (FRACTION_BITS + 1);
						state_q <= S_RESULT;
					end else begin
						dd_q    <= '0;
						m_q     <= '0;
						rc_q    <= '0;
						state_q <= S_TRIAL;
					end
				end
				S_TRIAL: begin
					trial_q <= (dd_q << 2) + RW'(xy_q);
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (rem4 >= trial_q) begin
						rem_q <= rem4 - trial_q;
						dd_q  <= (dd_q << 1) + RW'(xy_q);
						m_q   <= {m_q[MW-2:0], 1'b1};
					end else begin
						rem_q <= rem4;
						dd_q  <= dd_q << 1;
						m_q   <= {m_q[MW-2:0], 1'b0};
					end
					rc_q <= rc_q + 1'b1;
					if (rc_q == RCW'(FRACTION_BITS)) state_q <= S_RESULT;
					else state_q <= S_TRIAL;
				end
				S_RESULT: begin
					res_dist_q <= dist_val;
					res_inv_q  <= 1'b0;
					state_q    <= S_EMIT;
				end
				S_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q      <= 1'b1;
						m_dist_q        <= res_dist_q;
						m_inv_q         <= res_inv_q;
						sum_first_q     <= '0;
						sum_second_q    <= '0;
						sum_cross_q     <= '0;
						sum_sq_first_q  <= '0;
						sum_sq_second_q <= '0;
						element_count_q <= '0;
						saw_missing_q   <= 1'b0;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking stream testbench for correlation_distance, with a built-in distance predictor.
module tb_top;
	import cd_pkg::*;

	localparam int VW     = VALUE_WIDTH_DEF;
	localparam int FB     = FRACTION_BITS_DEF;
	localparam int DW     = FB + 2;
	localparam int SDW    = ((2*VW+7)/8)*8;
	localparam int MDW    = ((DW+7)/8)*8;
	localparam int VMAX   = (1 << (VW-1)) - 1;
	localparam int VMIN   = -(1 << (VW-1));
	localparam int SETTLE = 250;
	localparam int LIMIT  = 2000000;

	typedef struct {
		logic [VW-1:0] a;
		logic [VW-1:0] b;
		bit            miss;
		bit            lst;
		int            gap;
	} pair_t;

	typedef struct {
		logic [DW-1:0] distance;
		bit            invalid;
	} dist_t;

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [SDW-1:0]        s_tdata  = '0;
	logic                  s_tuser  = 1'b0;
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [MDW-1:0]        m_tdata;
	logic                  m_tuser;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [31:0]           pwdata   = '0;
	logic [31:0]           prdata;
	logic                  pready;

	pair_t pair_q[$];
	dist_t distance_q[$];

	bit    tx_fire      = 1'b0;
	bit    rx_fire      = 1'b0;
	int    gap_waited   = 0;
	int    stall_left   = 0;
	int    hold_left    = 0;
	bit    held         = 1'b0;
	int    results_seen = 0;
	int    err_count    = 0;
	int    cycles       = 0;

	// predictor state
	bit                 mode_centered = 1'b1;
	logic signed [63:0] sum_a, sum_b, sum_ab, sum_aa, sum_bb;
	int unsigned        pair_count;
	bit                 vec_flawed;

	correlation_distance i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	function automatic void clear_sums();
		sum_a      = '0;
		sum_b      = '0;
		sum_ab     = '0;
		sum_aa     = '0;
		sum_bb     = '0;
		pair_count = 0;
		vec_flawed = 1'b0;
	endfunction

	function automatic logic [DW-1:0] distance_of_sums();
		logic signed [127:0] n, sa, sb, p, x, y;
		logic [255:0]        pu, xy, pp;
		logic [63:0]         lo, hi, mid, odd, one;
		bit                  neg;
		one = 64'd1 << FB;
		n   = pair_count;
		sa  = sum_a;
		sb  = sum_b;
		if (mode_centered) begin
			p = n * sum_ab - sa * sb;
			x = n * sum_aa - sa * sa;
			y = n * sum_bb - sb * sb;
		end else begin
			p = sum_ab;
			x = sum_aa;
			y = sum_bb;
		end
		if (x <= 0 || y <= 0)
			return DW'(one);
		neg = (p < 0);
		if (neg)
			p = -p;
		pu = 256'(p);
		xy = 256'(x) * 256'(y);
		pp = (pu * pu) << (2*FB + 2);
		// largest q with (2q-1)^2 * X*Y <= 4^(F+1) * P^2
		lo = 0;
		hi = one;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			odd = 2 * mid - 1;
			if (256'(odd * odd) * xy <= pp)
				lo = mid;
			else
				hi = mid - 1;
		end
		return neg ? DW'(one + lo) : DW'(one - lo);
	endfunction

	function automatic bit take_pair(input logic [VW-1:0] ra, input logic [VW-1:0] rb,
			input bit miss, input bit lst, output dist_t res);
		logic signed [63:0] a, b;
		a = 64'(signed'(ra));
		b = 64'(signed'(rb));
		res.distance = '0;
		res.invalid  = 1'b0;
		if (pair_count >= MAX_LENGTH_DEF) begin
			vec_flawed = 1'b1;
		end else begin
			pair_count++;
			if (miss) begin
				vec_flawed = 1'b1;
			end else begin
				sum_a  += a;
				sum_b  += b;
				sum_ab += a * b;
				sum_aa += a * a;
				sum_bb += b * b;
			end
		end
		if (!lst)
			return 1'b0;
		if (vec_flawed || pair_count == 0)
			res.invalid = 1'b1;
		else
			res.distance = distance_of_sums();
		clear_sums();
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		err_count++;
		$display("tb_top: mismatch %s at cycle %0d: got %0d, expected %0d",
			what, cycles, got, want);
	endtask

	// monitor and checker
	always @(posedge clk) begin
		dist_t want;
		tx_fire <= s_tvalid && s_tready;
		rx_fire <= m_tvalid && m_tready;
		if (s_tvalid && s_tready) begin
			if (take_pair(s_tdata[VW-1:0], s_tdata[2*VW-1:VW], s_tuser, s_tlast, want))
				distance_q = {distance_q, want};
		end
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (distance_q.size() == 0) begin
				report_mismatch("unexpected result, distance", m_tdata, 0);
			end else begin
				want = distance_q.pop_front();
				if (m_tdata !== MDW'(want.distance))
					report_mismatch("distance", m_tdata, want.distance);
				if (m_tuser !== want.invalid)
					report_mismatch("invalid", m_tuser, want.invalid);
			end
		end
	end

	// sender
	always @(negedge clk) begin
		pair_t it;
		if (!s_tvalid || tx_fire) begin
			if (pair_q.size() > 0 && gap_waited < pair_q[0].gap) begin
				gap_waited++;
				s_tvalid <= 1'b0;
			end else if (pair_q.size() > 0) begin
				it = pair_q.pop_front();
				gap_waited = 0;
				s_tdata  <= SDW'({it.b, it.a});
				s_tuser  <= it.miss;
				s_tlast  <= it.lst;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (rx_fire) begin
			stall_left = ((results_seen / 20) % 4 == 3) ? 0 : $urandom_range(0, 16);
			if (results_seen >= 30 && !held) begin
				hold_left = 3000;
				held      = 1'b1;
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic set_mode(bit centered);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_CENTERED_MODE, 2'b00};
		pwdata  <= 32'(centered);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		mode_centered = centered;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pair_q.size() != 0 || s_tvalid || distance_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic push_pair(int a, int b, bit miss, bit lst, bit quiet);
		pair_t it;
		it.a    = a[VW-1:0];
		it.b    = b[VW-1:0];
		it.miss = miss;
		it.lst  = lst;
		it.gap  = quiet ? 0 : $urandom_range(0, 16);
		pair_q  = {pair_q, it};
	endtask

	function automatic int clamp_value(int v);
		if (v > VMAX)
			return VMAX;
		if (v < VMIN)
			return VMIN;
		return v;
	endfunction

	// 1: small magnitudes, 2: field extremes, else full range
	function automatic int draw_value(int kind);
		case (kind)
			1: return int'($urandom_range(0, 511)) - 256;
			2: begin
				case ($urandom_range(0, 4))
					0: return VMAX;
					1: return VMIN;
					2: return 0;
					3: return 1;
					default: return -1;
				endcase
			end
			default: return int'($urandom()) >>> (32 - VW);
		endcase
	endfunction

	// miss_at: index of the missing pair, -1 none, -2 scattered
	task automatic queue_vector(int len, int kind, int miss_at, bit quiet);
		int k, a, b, ca, noise;
		bit miss;
		ca = draw_value(0);
		for (k = 0; k < len; k++) begin
			noise = int'($urandom_range(0, 2047)) - 1024;
			case (kind)
				3: begin
					a = draw_value(0);
					b = clamp_value(a + noise);
				end
				4: begin
					a = draw_value(0);
					b = clamp_value(noise - a);
				end
				5: begin
					a = ca;
					b = draw_value(0);
				end
				default: begin
					a = draw_value(kind);
					b = draw_value(kind);
				end
			endcase
			miss = (k == miss_at) || (miss_at == -2 && $urandom_range(0, 3) == 0);
			push_pair(a, b, miss, k == len - 1, quiet);
		end
	endtask

	task automatic queue_random(int quota);
		int queued, len, pick, vec_no;
		queued = 0;
		vec_no = 0;
		while (queued < quota) begin
			len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
			pick = $urandom_range(0, 9);
			queue_vector(len, $urandom_range(0, 5),
				(pick == 0) ? int'($urandom_range(0, len - 1)) : ((pick == 1) ? -2 : -1),
				vec_no % 8 == 7);
			queued += len;
			vec_no++;
		end
	endtask

	initial begin
		int k;
		clear_sums();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_mode(1'b1);
		push_pair(VMAX, VMIN, 1'b0, 1'b1, 1'b0);
		push_pair(VMAX, VMAX, 1'b0, 1'b0, 1'b0);
		push_pair(VMIN, VMIN, 1'b0, 1'b1, 1'b0);
		push_pair(VMAX, VMIN, 1'b0, 1'b0, 1'b0);
		push_pair(VMIN, VMAX, 1'b0, 1'b1, 1'b0);
		push_pair(1, 2, 1'b0, 1'b0, 1'b0);
		push_pair(VMIN, VMAX, 1'b1, 1'b0, 1'b0);
		push_pair(3, 4, 1'b0, 1'b1, 1'b0);
		push_pair(5, 6, 1'b0, 1'b0, 1'b0);
		push_pair(7, 8, 1'b1, 1'b1, 1'b0);
		push_pair(100, 7, 1'b0, 1'b0, 1'b0);
		push_pair(100, -9, 1'b0, 1'b0, 1'b0);
		push_pair(100, 3, 1'b0, 1'b1, 1'b0);
		wait_drained();

		set_mode(1'b0);
		push_pair(VMAX, VMAX, 1'b0, 1'b1, 1'b0);
		push_pair(0, 5, 1'b0, 1'b1, 1'b0);
		push_pair(VMIN, VMAX, 1'b0, 1'b1, 1'b0);
		push_pair(3, -4, 1'b0, 1'b0, 1'b0);
		push_pair(-4, -3, 1'b0, 1'b1, 1'b0);
		push_pair(-1, -1, 1'b0, 1'b1, 1'b0);
		wait_drained();

		for (k = 0; k < 4; k++) begin
			set_mode(k % 2 == 0);
			queue_random(375);
			wait_drained();
		end

		set_mode(1'b1);
		queue_vector(5, 0, -1, 1'b0);
		wait_drained();

		if (err_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

@@ filelist.f @@
src/cd_pkg.sv
src/correlation_distance.sv
tb/sv/tb_top.sv
